FILE: design/pcv_pkg.sv
// Shared constants and types for the pressure change vote block.
`default_nettype none
package pcv_pkg;

   // Default sizing of the block.
   localparam int CHANNELS_DEF    = 3;
   localparam int SAMPLE_BITS_DEF = 12;

   // Fixed field widths.
   localparam int TALLY_BITS = 8;
   localparam int LIMIT_BITS = 12;
   localparam int SHIFT_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   // Register reset values.
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);
   localparam logic [TALLY_BITS-1:0] COUNT_RESET = TALLY_BITS'(5);
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(8);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANGE_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AVERAGE_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_SHIFT   = 2'd2;

   // Per-channel change direction.
   typedef enum logic [1:0] {
      DIR_STABLE  = 2'd0,
      DIR_HEAVIER = 2'd1,
      DIR_LIGHTER = 2'd2
   } dir_type;

   // Voted load movement.
   typedef enum logic [1:0] {
      MOVE_NONE     = 2'd0,
      MOVE_ARRIVED  = 2'd1,
      MOVE_DEPARTED = 2'd2
   } move_class_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_JUDGE,
      ST_EMIT
   } pcv_state_type;

endpackage
`default_nettype wire

FILE: design/pcv_div.sv
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none
module pcv_div import pcv_pkg::*; #(
   parameter int DIVIDEND_BITS = SAMPLE_BITS_DEF + TALLY_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [TALLY_BITS-1:0]    divisor,
   output logic                          done,
   output logic [DIVIDEND_BITS-1:0]      quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_BITS - 1);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic [DIVIDEND_BITS-1:0] dvd_ff;
   logic [DIVIDEND_BITS-1:0] dvd_in;
   logic [TALLY_BITS-1:0]    rem_ff;
   logic [TALLY_BITS-1:0]    rem_in;
   logic [TALLY_BITS-1:0]    div_ff;
   logic [TALLY_BITS:0]      rem_shift;
   logic                     fits;

   // One trial subtraction; the dividend register fills with quotient bits.
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DIVIDEND_BITS-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      if (fits) begin
         rem_in = TALLY_BITS'(rem_shift - {1'b0, div_ff});
      end else begin
         rem_in = rem_shift[TALLY_BITS-1:0];
      end
      dvd_in = {dvd_ff[DIVIDEND_BITS-2:0], fits};
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
`default_nettype wire

FILE: design/pressure_change_vote_core.sv
// Top level of the pressure change vote block: averaging, sequencer and vote.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_channel, req_sample
//   rsp_      out        rsp_valid/rsp_stall  rsp_move_class, rsp_direction_a/b/c,
//                                             rsp_heavier_total, rsp_lighter_total
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A sample that does not complete an average is accepted while the sequencer is idle.
// A completing sample holds the input while the bit-serial divider forms the average.
// When it completes the last channel, the sequencer judges the channels one per cycle,
// then the emit state loads the result register once the output is free.
// Reset is synchronous and needs no clearing pass. The result register frees the
// input side; only a new vote waits while an earlier result is stalled.
`default_nettype none
module pressure_change_vote_core import pcv_pkg::*; #(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_channel,
   input  wire logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_move_class,
   output logic [1:0]                     rsp_direction_a,
   output logic [1:0]                     rsp_direction_b,
   output logic [1:0]                     rsp_direction_c,
   output logic [1:0]                     rsp_heavier_total,
   output logic [1:0]                     rsp_lighter_total,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int SUM_BITS = SAMPLE_BITS + TALLY_BITS;
   localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_BITS = $clog2(CHANNELS + 1);
   localparam int CMP_BITS = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS) + 1;
   localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNELS - 1);

   pcv_state_type state_ff;
   pcv_state_type state_in;

   // Configuration registers.
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [TALLY_BITS-1:0] count_ff;
   logic [SHIFT_BITS-1:0] shift_ff;

   // Per-channel state.
   logic [SUM_BITS-1:0]    sum_ff   [CHANNELS];
   logic [TALLY_BITS-1:0]  tally_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] level_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] prev_ff  [CHANNELS];
   dir_type                dirs_ff  [CHANNELS];
   logic [CHANNELS-1:0]    mask_ff;
   logic [CHANNELS-1:0]    mask_new;

   logic [CH_BITS-1:0]  chan_ff;
   logic [CH_BITS-1:0]  idx_ff;
   logic [CNT_BITS-1:0] heavy_ff;
   logic [CNT_BITS-1:0] light_ff;

   // Result register.
   logic                  rsp_valid_ff;
   move_class_type        rsp_class_ff;
   dir_type               rsp_dir_ff [3];
   logic [1:0]            rsp_heavy_ff;
   logic [1:0]            rsp_light_ff;

   logic                   req_accept;
   logic                   req_in_range;
   logic [CH_BITS-1:0]     req_idx;
   logic [SUM_BITS-1:0]    sum_new;
   logic [TALLY_BITS-1:0]  tally_new;
   logic                   complete;
   logic                   div_start;
   logic                   div_done;
   logic [SUM_BITS-1:0]    div_quot;
   logic [SAMPLE_BITS-1:0] level_new;
   logic                   all_ready;
   logic [CMP_BITS-1:0]    now_x;
   logic [CMP_BITS-1:0]    before_x;
   logic [CMP_BITS-1:0]    limit_x;
   dir_type                judge_dir;
   logic                   last_ch;
   logic                   out_free;
   move_class_type         vote;
   dir_type                dir_out [3];

   // Input transfer and running sum update for the addressed channel.
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && (state_ff == ST_IDLE);
   assign req_in_range = (32'(req_channel) < CHANNELS);
   assign req_idx      = CH_BITS'(req_channel);
   assign sum_new      = sum_ff[req_idx] + SUM_BITS'(req_sample);
   assign tally_new    = tally_ff[req_idx] + 1'b1;
   assign complete     = (tally_new != '0) && (tally_new >= count_ff);
   assign div_start    = req_accept && req_in_range && complete;

   // Shared divider for the channel averages.
   pcv_div #(
      .DIVIDEND_BITS(SUM_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (tally_new),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign level_new = SAMPLE_BITS'(div_quot >> shift_ff);
   assign mask_new  = mask_ff | (CHANNELS'(1) << chan_ff);
   assign all_ready = &mask_new;

   // Judge one channel against its previous level.
   always_comb begin
      now_x    = CMP_BITS'(level_ff[idx_ff]);
      before_x = CMP_BITS'(prev_ff[idx_ff]);
      limit_x  = CMP_BITS'(limit_ff);
      judge_dir = DIR_STABLE;
      if (before_x != '0) begin
         if (now_x > before_x + limit_x) begin
            judge_dir = DIR_HEAVIER;
         end else if (before_x > now_x + limit_x) begin
            judge_dir = DIR_LIGHTER;
         end
      end
   end

   assign last_ch  = (idx_ff == LAST_CH);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Vote on the gathered heavier and lighter counts.
   always_comb begin
      if ((heavy_ff >= CNT_BITS'(2)) || ((heavy_ff == CNT_BITS'(1)) && (light_ff == '0))) begin
         vote = MOVE_ARRIVED;
      end else if (light_ff != '0) begin
         vote = MOVE_DEPARTED;
      end else begin
         vote = MOVE_NONE;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = all_ready ? ST_JUDGE : ST_IDLE;
            end
         end
         ST_JUDGE: begin
            if (last_ch) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control state, configuration and per-channel accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= COUNT_RESET;
         shift_ff     <= SHIFT_RESET;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]   <= '0;
            tally_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else begin
         // Configuration transfer.
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CHANGE_LIMIT:  limit_ff <= csr_data[LIMIT_BITS-1:0];
               CSR_AVERAGE_COUNT: count_ff <= csr_data[TALLY_BITS-1:0];
               CSR_LEVEL_SHIFT:   shift_ff <= csr_data[SHIFT_BITS-1:0];
               default: begin
               end
            endcase
         end
         // Accumulate the sample, or clear when the average completes.
         if (req_accept && req_in_range) begin
            if (complete) begin
               sum_ff[req_idx]   <= '0;
               tally_ff[req_idx] <= '0;
            end else begin
               sum_ff[req_idx]   <= sum_new;
               tally_ff[req_idx] <= tally_new;
            end
         end
         // Mark the channel ready; a full set starts a vote.
         if ((state_ff == ST_DIVIDE) && div_done) begin
            mask_ff <= all_ready ? '0 : mask_new;
         end
         // The previous level follows the judged level.
         if (state_ff == ST_JUDGE) begin
            prev_ff[idx_ff] <= level_ff[idx_ff];
         end
         // Result register valid.
         if ((state_ff == ST_EMIT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: levels, judge results and the result fields.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         chan_ff <= req_idx;
      end
      if ((state_ff == ST_DIVIDE) && div_done) begin
         level_ff[chan_ff] <= level_new;
         idx_ff            <= '0;
         heavy_ff          <= '0;
         light_ff          <= '0;
      end
      if (state_ff == ST_JUDGE) begin
         dirs_ff[idx_ff] <= judge_dir;
         if (judge_dir == DIR_HEAVIER) begin
            heavy_ff <= heavy_ff + 1'b1;
         end
         if (judge_dir == DIR_LIGHTER) begin
            light_ff <= light_ff + 1'b1;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_class_ff <= vote;
         rsp_heavy_ff <= 2'(heavy_ff);
         rsp_light_ff <= 2'(light_ff);
         for (int k = 0; k < 3; k++) begin
            rsp_dir_ff[k] <= dir_out[k];
         end
      end
   end

   // Direction fields exist for the first three channels; absent ones read stable.
   for (genvar g = 0; g < 3; g++) begin : g_dir
      if (g < CHANNELS) begin : g_present
         assign dir_out[g] = dirs_ff[g];
      end else begin : g_absent
         assign dir_out[g] = DIR_STABLE;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_move_class    = rsp_class_ff;
   assign rsp_direction_a   = rsp_dir_ff[0];
   assign rsp_direction_b   = rsp_dir_ff[1];
   assign rsp_direction_c   = rsp_dir_ff[2];
   assign rsp_heavier_total = rsp_heavy_ff;
   assign rsp_lighter_total = rsp_light_ff;
   assign csr_ready         = 1'b1;

endmodule
`default_nettype wire
